>>> rtl/d16g_pkg.sv
`default_nettype none

package d16g_pkg;

    localparam int ID_WIDTH_DEFAULT = 32;
    localparam int HALF_WIDTH       = 16;
    localparam int WORD_WIDTH       = 32;
    localparam int OUT_ID_WIDTH     = 32;
    localparam logic [HALF_WIDTH-1:0] ESCAPE_ADD = 16'hFFFF;

    typedef enum logic [6:0] {
        PH_ID_LO    = 7'b0000001,
        PH_ID_HI    = 7'b0000010,
        PH_CNT_LO   = 7'b0000100,
        PH_CNT_HI   = 7'b0001000,
        PH_FIRST_LO = 7'b0010000,
        PH_FIRST_HI = 7'b0100000,
        PH_GAPS     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [OUT_ID_WIDTH-1:0] node_id;
        logic [OUT_ID_WIDTH-1:0] neighbor;
        logic                    last_of_record;
        logic                    empty_record;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/delta16_gap_decoder.sv
// Gap-coded adjacency stream decoder.
// The slave channel takes one 16-bit halfword per item. Each record is a
// node id, a neighbor count and, for a nonzero count, a first neighbor,
// each as two halfwords, low half first, then gap codes. A zero code adds
// 65535 to the running gap; a nonzero code closes it, giving a neighbor.
// The master channel carries one item per decoded neighbor: node id and
// neighbor in tdata, tlast on the record's final neighbor, and tuser set on
// the single item that an empty record produces.
// An input item passes an input register and then the decode logic, which
// writes the result register, which drives the master channel. One halfword
// is taken every cycle unless the receiver stalls with a result pending; the
// decode state update (two chained ID_WIDTH-bit adds and a compare) is
// combinational logic between the input register and the state registers.
// When the receiver stalls, the result register holds and the input
// register fills; tready then drops until the result is taken.
// Reset returns the decoder to expecting the low half of a node id and
// empties both registers.
`default_nettype none

module delta16_gap_decoder #(
    parameter int ID_WIDTH = d16g_pkg::ID_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [15:0] half_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [31:0] node_id, [63:32] neighbor
    output logic             m_axis_tlast,  // last_of_record
    output logic             m_axis_tuser   // empty_record
);
    import d16g_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic [HALF_WIDTH-1:0] in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg;

    logic    advance;
    logic    in_accept;
    logic    emit;
    result_t result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    d16g_core #(
        .ID_WIDTH (ID_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .half_word (in_data_reg),
        .emit      (emit),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.neighbor, out_data_reg.node_id};
    assign m_axis_tlast  = out_data_reg.last_of_record;
    assign m_axis_tuser  = out_data_reg.empty_record;

endmodule

`default_nettype wire

>>> rtl/d16g_core.sv
`default_nettype none

module d16g_core #(
    parameter int ID_WIDTH = d16g_pkg::ID_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [d16g_pkg::HALF_WIDTH-1:0] half_word,
    output logic                                emit,
    output d16g_pkg::result_t                   result
);
    import d16g_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [HALF_WIDTH-1:0]   low_half_hold_reg, low_half_hold_next;
    logic [ID_WIDTH-1:0]     current_node_reg, current_node_next;
    logic [WORD_WIDTH-1:0]   remaining_count_reg, remaining_count_next;
    logic [ID_WIDTH-1:0]     previous_neighbor_reg, previous_neighbor_next;
    logic [ID_WIDTH-1:0]     gap_accumulator_reg, gap_accumulator_next;

    logic [WORD_WIDTH-1:0]          word;
    logic [ID_WIDTH+WORD_WIDTH-1:0] word_ext;
    logic [ID_WIDTH-1:0]            word_id;
    logic [HALF_WIDTH-1:0]          gap_add;
    logic [ID_WIDTH-1:0]            gap_sum;
    logic [ID_WIDTH-1:0]            neighbor_sum;
    logic [WORD_WIDTH-1:0]          count_dec;
    logic [ID_WIDTH-1:0]            emit_neighbor;
    logic [OUT_ID_WIDTH+ID_WIDTH-1:0] node_ext;
    logic [OUT_ID_WIDTH+ID_WIDTH-1:0] nb_ext;

    assign word     = {half_word, low_half_hold_reg};
    // Zero-pad on the left so the select works for any ID width.
    assign word_ext = {{ID_WIDTH{1'b0}}, word};
    assign word_id  = word_ext[ID_WIDTH-1:0];

    // A zero code stands for the escape increment.
    assign gap_add      = (half_word == '0) ? ESCAPE_ADD : half_word;
    assign gap_sum      = gap_accumulator_reg + ID_WIDTH'(gap_add);
    assign neighbor_sum = previous_neighbor_reg + gap_sum;
    assign count_dec    = remaining_count_reg - WORD_WIDTH'(1);

    assign node_ext = {{OUT_ID_WIDTH{1'b0}}, current_node_reg};
    assign nb_ext   = {{OUT_ID_WIDTH{1'b0}}, emit_neighbor};

    always_comb
    begin
        phase_next             = phase_reg;
        low_half_hold_next     = low_half_hold_reg;
        current_node_next      = current_node_reg;
        remaining_count_next   = remaining_count_reg;
        previous_neighbor_next = previous_neighbor_reg;
        gap_accumulator_next   = gap_accumulator_reg;
        emit                   = 1'b0;
        emit_neighbor          = '0;
        result.last_of_record  = 1'b0;
        result.empty_record    = 1'b0;

        unique case (phase_reg)
            PH_ID_HI:
            begin
                current_node_next = word_id;
                phase_next        = PH_CNT_LO;
            end
            PH_CNT_LO:
            begin
                low_half_hold_next = half_word;
                phase_next         = PH_CNT_HI;
            end
            PH_FIRST_LO:
            begin
                low_half_hold_next = half_word;
                phase_next         = PH_FIRST_HI;
            end
            PH_CNT_HI:
            begin
                if (word == '0)
                begin
                    remaining_count_next  = '0;
                    phase_next            = PH_ID_LO;
                    emit                  = 1'b1;
                    result.last_of_record = 1'b1;
                    result.empty_record   = 1'b1;
                end
                else
                begin
                    remaining_count_next = word - WORD_WIDTH'(1);
                    phase_next           = PH_FIRST_LO;
                end
            end
            PH_FIRST_HI:
            begin
                previous_neighbor_next = word_id;
                gap_accumulator_next   = '0;
                phase_next             = (remaining_count_reg == '0) ? PH_ID_LO : PH_GAPS;
                emit                   = 1'b1;
                emit_neighbor          = word_id;
                result.last_of_record  = (remaining_count_reg == '0);
            end
            PH_GAPS:
            begin
                if (half_word == '0)
                begin
                    gap_accumulator_next = gap_sum;
                end
                else
                begin
                    previous_neighbor_next = neighbor_sum;
                    gap_accumulator_next   = '0;
                    remaining_count_next   = count_dec;
                    if (count_dec == '0)
                    begin
                        phase_next = PH_ID_LO;
                    end
                    emit                  = 1'b1;
                    emit_neighbor         = neighbor_sum;
                    result.last_of_record = (count_dec == '0);
                end
            end
            default:
            begin
                // Expecting the low half of a node id.
                low_half_hold_next = half_word;
                phase_next         = PH_ID_HI;
            end
        endcase

        result.node_id  = node_ext[OUT_ID_WIDTH-1:0];
        result.neighbor = nb_ext[OUT_ID_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_ID_LO;
            low_half_hold_reg     <= '0;
            current_node_reg      <= '0;
            remaining_count_reg   <= '0;
            previous_neighbor_reg <= '0;
            gap_accumulator_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg             <= phase_next;
            low_half_hold_reg     <= low_half_hold_next;
            current_node_reg      <= current_node_next;
            remaining_count_reg   <= remaining_count_next;
            previous_neighbor_reg <= previous_neighbor_next;
            gap_accumulator_reg   <= gap_accumulator_next;
        end
    end

endmodule

`default_nettype wire
